// ----- hw/rtl/fan_step_hysteresis_table_assert.svh -----
// Assertion macros used by the checker file of the fan step table.
`ifndef FAN_STEP_HYSTERESIS_TABLE_ASSERT_SVH
`define FAN_STEP_HYSTERESIS_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FSHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FSHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fsht_pkg.sv -----
// Package with types, constants and table helpers of the fan step table.
`timescale 1ns / 1ps
package fsht_pkg;

  localparam int LEVELS = 8;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int CNT_W  = LVL_W + 1;
  localparam int REG_W  = 64;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_ON_POINTS     = 3'd0,
    REG_OFF_POINTS    = 3'd1,
    REG_LEVELS_IN_USE = 3'd2,
    REG_FAN0_RPM_LOW  = 3'd3,
    REG_FAN0_RPM_HIGH = 3'd4,
    REG_FAN1_RPM_LOW  = 3'd5,
    REG_FAN1_RPM_HIGH = 3'd6
  } reg_idx_t;

  localparam logic [1:0] PS_ON      = 2'd0;
  localparam logic [1:0] PS_SUSPEND = 2'd1;

  typedef struct packed {
    logic signed [8:0] temperature;
    logic              fan_channel;
    logic [1:0]        power_state;
  } sample_t;

  typedef struct packed {
    logic        drive_fan;
    logic [15:0] target_rpm;
    logic [2:0]  fan_level;
  } result_t;

  typedef struct packed {
    logic [REG_W-1:0] on_points;
    logic [REG_W-1:0] off_points;
    logic [3:0]       levels_in_use;
    logic [REG_W-1:0] fan0_rpm_low;
    logic [REG_W-1:0] fan0_rpm_high;
    logic [REG_W-1:0] fan1_rpm_low;
    logic [REG_W-1:0] fan1_rpm_high;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step_down;
    logic step_up;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ps_on;
    logic temp_lt;
    logic temp_gt;
    logic down_go;
    logic up_go;
    logic out_free;
  } status_t;

  function automatic logic signed [8:0] point_at(logic [REG_W-1:0] pts,
                                                 logic [LVL_W-1:0] idx);
    logic [7:0] b;
    b = pts[idx*8 +: 8];
    return {b[7], b};
  endfunction

  function automatic logic [15:0] rpm_at(cfg_t cfg, logic ch, logic [LVL_W-1:0] lvl);
    logic [REG_W-1:0] r;
    case ({ch, lvl[2]})
      2'b00:   r = cfg.fan0_rpm_low;
      2'b01:   r = cfg.fan0_rpm_high;
      2'b10:   r = cfg.fan1_rpm_low;
      default: r = cfg.fan1_rpm_high;
    endcase
    return r[lvl[1:0]*16 +: 16];
  endfunction

  function automatic logic [CNT_W-1:0] eff_levels(logic [3:0] v);
    if (v == 4'd0) begin
      return CNT_W'(1);
    end else if (v > 4'(LEVELS)) begin
      return CNT_W'(LEVELS);
    end
    return CNT_W'(v);
  endfunction

endpackage

// ----- hw/rtl/fsht_cfg.sv -----
// Configuration register file of the fan step table.
`timescale 1ns / 1ps
module fsht_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fsht_pkg::IDX_W-1:0]      cfg_index,
  input  logic [fsht_pkg::REG_W-1:0]      cfg_data,
  output fsht_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_points     <= '0;
      cfg.off_points    <= '0;
      cfg.levels_in_use <= 4'd1;
      cfg.fan0_rpm_low  <= '0;
      cfg.fan0_rpm_high <= '0;
      cfg.fan1_rpm_low  <= '0;
      cfg.fan1_rpm_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsht_pkg::REG_ON_POINTS:     cfg.on_points     <= cfg_data;
        fsht_pkg::REG_OFF_POINTS:    cfg.off_points    <= cfg_data;
        fsht_pkg::REG_LEVELS_IN_USE: cfg.levels_in_use <= cfg_data[3:0];
        fsht_pkg::REG_FAN0_RPM_LOW:  cfg.fan0_rpm_low  <= cfg_data;
        fsht_pkg::REG_FAN0_RPM_HIGH: cfg.fan0_rpm_high <= cfg_data;
        fsht_pkg::REG_FAN1_RPM_LOW:  cfg.fan1_rpm_low  <= cfg_data;
        fsht_pkg::REG_FAN1_RPM_HIGH: cfg.fan1_rpm_high <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/fsht_dp.sv -----
// Datapath of the fan step table: level walk, state and result register.
`timescale 1ns / 1ps
module fsht_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  fsht_pkg::cfg_t       cfg,
  input  fsht_pkg::sample_t    sample,
  input  fsht_pkg::cmd_t       cmd,
  output fsht_pkg::status_t    status,
  output logic                 result_valid,
  input  logic                 result_ready,
  output fsht_pkg::result_t    result
);

  logic signed [8:0]               temp_r;
  logic                            ch_r;
  logic [1:0]                      ps_r;
  logic [fsht_pkg::CNT_W-1:0]      cnt;
  logic [fsht_pkg::LVL_W-1:0]      level_now;
  logic signed [8:0]               last_temperature;
  logic [fsht_pkg::CNT_W-1:0]      n_eff;
  logic [fsht_pkg::LVL_W-1:0]      level_clamped;
  logic [fsht_pkg::LVL_W-1:0]      level_report;
  logic signed [8:0]               off_pt;
  logic signed [8:0]               on_pt;
  fsht_pkg::result_t               result_next;

  always_comb begin
    n_eff  = fsht_pkg::eff_levels(cfg.levels_in_use);
    off_pt = fsht_pkg::point_at(cfg.off_points, cnt[fsht_pkg::LVL_W-1:0]);
    on_pt  = fsht_pkg::point_at(cfg.on_points, cnt[fsht_pkg::LVL_W-1:0]);

    if ({1'b0, level_now} >= n_eff) begin
      level_clamped = fsht_pkg::LVL_W'(n_eff - 1'b1);
    end else begin
      level_clamped = level_now;
    end

    status.ps_on    = (ps_r == fsht_pkg::PS_ON);
    status.temp_lt  = (temp_r < last_temperature);
    status.temp_gt  = (temp_r > last_temperature);
    status.down_go  = (cnt != '0) && (temp_r <= off_pt);
    status.up_go    = (cnt < n_eff) && (temp_r >= on_pt);
    status.out_free = !result_valid || result_ready;

    level_report            = status.ps_on ? level_clamped : level_now;
    result_next.fan_level   = level_report;
    result_next.drive_fan   = status.ps_on || (ps_r == fsht_pkg::PS_SUSPEND);
    result_next.target_rpm  = status.ps_on ? fsht_pkg::rpm_at(cfg, ch_r, level_clamped)
                                           : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now        <= '0;
      last_temperature <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (cmd.step_down) begin
        level_now <= fsht_pkg::LVL_W'(cnt - 1'b1);
      end else if (cmd.step_up) begin
        level_now <= cnt[fsht_pkg::LVL_W-1:0];
      end else if (cmd.finish && status.ps_on) begin
        level_now        <= level_clamped;
        last_temperature <= temp_r;
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_r <= sample.temperature;
      ch_r   <= sample.fan_channel;
      ps_r   <= sample.power_state;
      cnt    <= {1'b0, level_now};
    end else if (cmd.step_down) begin
      cnt <= cnt - 1'b1;
    end else if (cmd.step_up) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.finish) begin
      result <= result_next;
    end
  end

endmodule

// ----- hw/rtl/fsht_ctrl.sv -----
// Controller state machine of the fan step table.
`timescale 1ns / 1ps
module fsht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  fsht_pkg::status_t    status,
  output fsht_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_DOWN   = 5'b00100,
    S_UP     = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    sample_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (!status.ps_on) begin
          state_next = S_FINISH;
        end else if (status.temp_lt) begin
          state_next = S_DOWN;
        end else if (status.temp_gt) begin
          state_next = S_UP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DOWN: begin
        if (status.down_go) begin
          cmd.step_down = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_UP: begin
        if (status.up_go) begin
          cmd.step_up = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/fan_step_hysteresis_table.sv -----
// Sequence: a request is loaded in IDLE; START sends an equal sample or power not on straight
// to FINISH, otherwise to DOWN or UP, which step one level per passing level test before FINISH.
// The result is registered in FINISH, which stalls while the result register is still full.
// Requests: one at a time; a new request is taken only after the result is registered.
// Reset: synchronous; level 0, previous temperature 0, levels_in_use 1.
`timescale 1ns / 1ps
module fan_step_hysteresis_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  fsht_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output fsht_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [fsht_pkg::IDX_W-1:0]      cfg_index,
  input  logic [fsht_pkg::REG_W-1:0]      cfg_data
);

  fsht_pkg::cfg_t    cfg;
  fsht_pkg::cmd_t    cmd;
  fsht_pkg::status_t status;

  fsht_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fsht_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  fsht_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- hw/rtl/fsht_checker.sv -----
// Port-level assertion checker for the fan step table, with its bind.
`timescale 1ns / 1ps
`include "fan_step_hysteresis_table_assert.svh"
module fsht_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input fsht_pkg::result_t result
);

  `FSHT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
  `FSHT_ASSERT_NOW(a_idle_rpm_zero, result_valid && !result.drive_fan, result.target_rpm == 16'd0, "undriven result carries rpm")
  `FSHT_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "request taken while busy")
  `FSHT_ASSERT_NOW(a_ready_after_result, $rose(result_valid), sample_ready, "controller not idle after result")

endmodule

bind fan_step_hysteresis_table fsht_checker u_fsht_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the fan step table: predicts level and rpm per sample.
`timescale 1ns / 1ps
module tb;
  import fsht_pkg::*;

  localparam logic [1:0] PS_OTHER = 2'd2;
  localparam logic [1:0] PS_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 135;

  class fan_table_predictor;
    logic [63:0] on_pts;
    logic [63:0] off_pts;
    logic [3:0]  level_count;
    logic [63:0] rpm_word [2][2];
    int          level_now;
    int          last_temp;
    int          errors;
    result_t     due_results [$];

    function new();
      on_pts = '0;
      off_pts = '0;
      level_count = 4'd1;
      rpm_word = '{'{64'd0, 64'd0}, '{64'd0, 64'd0}};
      level_now = 0;
      last_temp = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] d);
      case (idx)
        REG_ON_POINTS:     on_pts = d;
        REG_OFF_POINTS:    off_pts = d;
        REG_LEVELS_IN_USE: level_count = d[3:0];
        REG_FAN0_RPM_LOW:  rpm_word[0][0] = d;
        REG_FAN0_RPM_HIGH: rpm_word[0][1] = d;
        REG_FAN1_RPM_LOW:  rpm_word[1][0] = d;
        REG_FAN1_RPM_HIGH: rpm_word[1][1] = d;
        default: ;
      endcase
    endfunction

    function int trip_point(logic [63:0] pts, int lvl);
      logic signed [7:0] b;
      b = pts[lvl*8 +: 8];
      return b;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_sample(sample_t s);
      int          t;
      int          n;
      int          i;
      logic [63:0] w;
      result_t     r;
      t = $signed(s.temperature);
      n = level_count;
      if (n < 1) n = 1;
      if (n > LEVELS) n = LEVELS;
      r.drive_fan = 1'b0;
      r.target_rpm = 16'd0;
      case (s.power_state)
        PS_ON: begin
          if (t < last_temp) begin
            for (i = level_now; i > 0; i--) begin
              if (t <= trip_point(off_pts, i)) level_now = i - 1;
              else break;
            end
          end else if (t > last_temp) begin
            for (i = level_now; i < n; i++) begin
              if (t >= trip_point(on_pts, i)) level_now = i;
              else break;
            end
          end
          if (level_now >= n) level_now = n - 1;
          last_temp = t;
          w = rpm_word[s.fan_channel][level_now / 4];
          r.drive_fan = 1'b1;
          r.target_rpm = w[(level_now % 4)*16 +: 16];
        end
        PS_SUSPEND: begin
          r.drive_fan = 1'b1;
        end
        default: ;
      endcase
      r.fan_level = level_now[2:0];
      due_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with no sample pending: %p", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.drive_fan !== want.drive_fan) begin
        $error("drive_fan expected %0d actual %0d", want.drive_fan, got.drive_fan);
        errors++;
      end
      if (got.target_rpm !== want.target_rpm) begin
        $error("target_rpm expected %0d actual %0d", want.target_rpm, got.target_rpm);
        errors++;
      end
      if (got.fan_level !== want.fan_level) begin
        $error("fan_level expected %0d actual %0d", want.fan_level, got.fan_level);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;
  bit                   quiet = 1'b0;
  int                   cycles = 0;
  fan_table_predictor   sb;

  fan_step_hysteresis_table u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_ready = quiet || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  function automatic logic [63:0] ramp(int base, int step);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[i*8 +: 8] = 8'(base + step*i);
    return v;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [63:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic load_table(logic [63:0] on_w, logic [63:0] off_w, int lv,
                            logic [63:0] f0l, logic [63:0] f0h,
                            logic [63:0] f1l, logic [63:0] f1h);
    write_reg(REG_ON_POINTS, on_w);
    write_reg(REG_OFF_POINTS, off_w);
    write_reg(REG_LEVELS_IN_USE, {$urandom, 28'($urandom), 4'(lv)});
    write_reg(REG_FAN0_RPM_LOW, f0l);
    write_reg(REG_FAN0_RPM_HIGH, f0h);
    write_reg(REG_FAN1_RPM_LOW, f1l);
    write_reg(REG_FAN1_RPM_HIGH, f1h);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_sample(int temp, bit ch, logic [1:0] ps);
    sample_t s;
    s.temperature = 9'(temp);
    s.fan_channel = ch;
    s.power_state = ps;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      sample_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    sample = s;
    sample_valid = 1'b1;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(s);
  endtask

  task automatic drain();
    @(negedge clk);
    sample_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int          p;
    int          k;
    int          r;
    int          cur;
    int          lo;
    int          hi;
    int          base;
    int          step;
    int          hyst;
    logic [63:0] on_w;
    logic [63:0] off_w;
    logic [63:0] rpm_w [4];
    int          lvl_pick [PHASES] = '{8, 1, 0, 15, 4, 9, 8, 2, 7, 3, 5, 6};

    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Trigger points 20, 30 .. 90 and release points four degrees lower.
    load_table(ramp(20, 10), ramp(16, 10), 8, 64'd0, rand_word(), rand_word(),
               64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(0, 1'b0, PS_ON);
    send_sample(25, 1'b0, PS_ON);
    send_sample(30, 1'b1, PS_ON);
    send_sample(255, 1'b0, PS_ON);
    send_sample(255, 1'b1, PS_ON);
    send_sample(86, 1'b0, PS_ON);
    send_sample(85, 1'b1, PS_SUSPEND);
    send_sample(-1, 1'b0, PS_OTHER);
    send_sample(100, 1'b1, PS_SPARE);
    send_sample(-256, 1'b0, PS_ON);
    send_sample(-256, 1'b1, PS_ON);
    send_sample(50, 1'b0, PS_ON);
    send_sample(49, 1'b1, PS_ON);
    send_sample(46, 1'b0, PS_ON);
    send_sample(-128, 1'b1, PS_ON);
    send_sample(127, 1'b0, PS_ON);
    send_sample(127, 1'b1, PS_SUSPEND);
    send_sample(-200, 1'b1, PS_OTHER);
    send_sample(89, 1'b1, PS_ON);
    drain();

    for (p = 0; p < PHASES; p++) begin
      lo = -140;
      hi = 140;
      case (p % 4)
        0: begin
          base = int'($urandom_range(0, 140)) - 100;
          step = $urandom_range(2, 10);
          hyst = $urandom_range(0, 6);
          on_w = ramp(base, step);
          off_w = ramp(base - hyst, step);
          lo = base - 20;
          hi = base + 7*step + 20;
        end
        1: begin
          on_w = rand_word();
          off_w = rand_word();
        end
        2: begin
          if (p == 2) begin
            on_w = 64'h8080_8080_8080_8080;
            off_w = 64'h7F7F_7F7F_7F7F_7F7F;
          end else if (p == 6) begin
            on_w = 64'h7F7F_7F7F_7F7F_7F7F;
            off_w = 64'h8080_8080_8080_8080;
          end else begin
            on_w = 64'd0;
            off_w = 64'd0;
          end
        end
        default: begin
          on_w = 64'hFFFF_FFFF_FFFF_FFFF;
          off_w = 64'd0;
        end
      endcase
      for (k = 0; k < 4; k++) begin
        if (p == 2) rpm_w[k] = 64'd0;
        else if (p == 3) rpm_w[k] = 64'hFFFF_FFFF_FFFF_FFFF;
        else rpm_w[k] = rand_word();
      end
      load_table(on_w, off_w, lvl_pick[p], rpm_w[0], rpm_w[1], rpm_w[2], rpm_w[3]);
      quiet = (p == 5);
      cur = lo + (hi - lo) / 2;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r >= 82) begin
          send_sample(int'($urandom_range(0, 511)) - 256, 1'($urandom),
                      2'($urandom_range(0, 3)));
        end else begin
          if (r < 55) cur = cur + int'($urandom_range(0, 12)) - 6;
          else if (r < 70) cur = lo + int'($urandom_range(0, hi - lo));
          if (cur < -256) cur = -256;
          if (cur > 255) cur = 255;
          send_sample(cur, 1'($urandom), PS_ON);
        end
      end
      drain();
    end

    quiet = 1'b0;
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
